// File: design/itda_pkg.sv
// Package for the integer to decimal ASCII converter.
// Holds the character codes, the default value width and the digit-step width.
// No dependencies.
package itda_pkg;

	localparam int VALUE_BITS_DEF = 32;

	// bits of the magnitude folded into the BCD register per cycle
	localparam int STEP_BITS = 4;

	localparam logic [6:0] CHAR_ZERO  = 7'd48;
	localparam logic [6:0] CHAR_MINUS = 7'd45;

endpackage

// File: design/int_to_decimal_ascii.sv
// Signed binary to decimal ASCII converter, characters most significant first.
// Sequence: after a request is accepted, the magnitude is converted by the shared shift-add-3
// BCD unit, then the leading digit is found, then the sign and the digits are loaded in turn.
// One value at a time: not ready again until the last character is loaded, and output
// back-pressure holds the loading of each character.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
// Depends on itda_pkg.
module int_to_decimal_ascii #(
	parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // [VALUE_BITS-1:0] value
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [7:0]                           m_tdata,  // [6:0] char_out, [7] zero
	output logic                                 m_tlast   // last
);

	import itda_pkg::*;

	localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W  = DIGITS * 4;
	localparam int STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int SH_W   = STEPS * STEP_BITS;
	localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int IDX_W  = $clog2(DIGITS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [SH_W-1:0]    sh_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   step_q;
	logic [IDX_W-1:0]   idx_q;
	logic               neg_q;
	logic               m_tvalid_q;
	logic [6:0]         char_q;
	logic               last_q;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic [BCD_W-1:0]      bcd_next;
	logic [IDX_W-1:0]      top_idx;
	logic                  out_free;
	logic [3:0]            digit;

	assign raw = s_tdata[VALUE_BITS-1:0];
	// two's complement negate also gives the most negative value's magnitude exactly
	assign mag = raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

	// shared shift-add-3 unit: folds STEP_BITS magnitude bits into the BCD register
	always_comb begin
		logic [BCD_W-1:0] b;
		b = bcd_q;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (b[d*4 +: 4] >= 4'd5) begin
					b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], sh_q[SH_W-1-s]};
		end
		bcd_next = b;
	end

	// highest non-zero digit, digit 0 when the value is zero
	always_comb begin
		top_idx = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				top_idx = IDX_W'(d);
			end
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign digit    = bcd_q[idx_q*4 +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			step_q     <= '0;
			idx_q      <= '0;
			neg_q      <= 1'b0;
		end else begin
			// a new character replaces the one taken; otherwise a taken one clears valid
			if ((state_q == ST_EMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						neg_q   <= raw[VALUE_BITS-1];
						sh_q    <= SH_W'(mag);
						bcd_q   <= '0;
						step_q  <= CNT_W'(STEPS - 1);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q <= bcd_next;
					sh_q  <= sh_q << STEP_BITS;
					if (step_q == '0) begin
						state_q <= ST_SCAN;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_SCAN: begin
					idx_q   <= top_idx;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (neg_q) begin
							char_q <= CHAR_MINUS;
							last_q <= 1'b0;
							neg_q  <= 1'b0;
						end else begin
							char_q <= CHAR_ZERO + {3'd0, digit};
							last_q <= (idx_q == '0);
							if (idx_q == '0) begin
								state_q <= ST_IDLE;
							end else begin
								idx_q <= idx_q - 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

endmodule

// File: design/itda_check.sv
// Port-level checks for the integer to decimal ASCII converter, bound to the top level.
// Depends on itda_pkg and int_to_decimal_ascii.
module itda_check #(
	parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // [VALUE_BITS-1:0] value
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [7:0]                           m_tdata,  // [6:0] char_out, [7] zero
	input logic                                 m_tlast   // last
);

	import itda_pkg::*;

	// a held character must not change under back-pressure
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// one value at a time: the converter is busy right after taking a request
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while converting");

	// only a minus sign or a decimal digit is ever shown
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] == CHAR_MINUS) ||
			((m_tdata[6:0] >= CHAR_ZERO) && (m_tdata[6:0] <= CHAR_ZERO + 7'd9)))
		else $error("bad character");

	// the sign is never the end of the text, and a digit follows it at once
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[6:0] == CHAR_MINUS) |-> !m_tlast)
		else $error("sign marked last");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && (m_tdata[6:0] == CHAR_MINUS) |=>
			m_tvalid && (m_tdata[6:0] != CHAR_MINUS))
		else $error("no digit after sign");

endmodule

bind int_to_decimal_ascii itda_check #(.VALUE_BITS(VALUE_BITS)) u_itda_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// File: sim/testbench.sv
// Testbench for int_to_decimal_ascii: signed values in, decimal ASCII characters out.
// A scoreboard class predicts each value's text and checks the character stream.
// Depends on itda_pkg and the int_to_decimal_ascii RTL.

typedef struct {
	logic [6:0] ch;
	logic       final_char;
} text_char_t;

class decimal_text_board;
	text_char_t expected_chars[$];
	int         errors;

	function new();
		errors = 0;
	endfunction

	// Queue the characters that one accepted request should produce
	function void note_value(logic [31:0] value);
		logic [31:0] mag;
		logic [3:0]  digits[$];
		text_char_t  c;
		mag = value[31] ? (~value + 32'd1) : value;
		// least significant digit first; zero still gives one digit
		do begin
			digits.push_back(4'(mag % 32'd10));
			mag = mag / 32'd10;
		end while (mag != 0);
		if (value[31]) begin
			c.ch = itda_pkg::CHAR_MINUS;
			c.final_char = 1'b0;
			expected_chars.push_back(c);
		end
		for (int i = digits.size() - 1; i >= 0; i--) begin
			c.ch = itda_pkg::CHAR_ZERO + 7'(digits[i]);
			c.final_char = (i == 0);
			expected_chars.push_back(c);
		end
	endfunction

	function void check_char(logic [6:0] ch, logic final_char);
		text_char_t e;
		if (expected_chars.size() == 0) begin
			$error("unexpected character %0d (last %0b)", ch, final_char);
			errors++;
			return;
		end
		e = expected_chars.pop_front();
		if (ch !== e.ch) begin
			$error("char_out: expected %0d, got %0d", e.ch, ch);
			errors++;
		end
		if (final_char !== e.final_char) begin
			$error("last: expected %0b, got %0b", e.final_char, final_char);
			errors++;
		end
	endfunction

	function int pending();
		return expected_chars.size();
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [6:0] char_out, [7] zero
	logic        m_tlast;   // last

	decimal_text_board board;
	bit                idle_on;

	int_to_decimal_ascii #(.VALUE_BITS(32)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	task automatic send_value(logic [31:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		board.note_value(value);
	endtask

	// random value with a spread of digit counts and both signs
	function automatic logic [31:0] random_value();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(0, 3) != 0)
			v = v >> $urandom_range(0, 31);
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// sink side: random back-pressure
	initial begin
		int g;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			g = pick_gap();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_char(m_tdata[6:0], m_tlast);
	end

	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [31:0] directed[$];
		int          waited;
		board    = new();
		idle_on  = 0;
		arst_n   = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, zero, digit-count boundaries, alternating bit patterns
		directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
			32'd999999999, -32'sd999999999, 32'h5555_5555, 32'hAAAA_AAAA,
			32'd12345, -32'sd12345, -32'sd9, 32'd4294967, 32'hFFFF_FFFE};
		foreach (directed[i])
			send_value(directed[i]);

		idle_on = 1;
		for (int i = 0; i < 80; i++)
			send_value(random_value());
		// a stretch at full rate on both sides
		idle_on = 0;
		for (int i = 0; i < 20; i++)
			send_value(random_value());
		s_tvalid <= 1'b0;

		waited = 0;
		while (board.pending() > 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (board.pending() > 0) begin
			$error("%0d characters never arrived", board.pending());
			board.errors++;
		end

		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
